### src/normal_cdf_approx_top_assert.svh
// ----------------------------------------------------------------------------
// normal_cdf_approx_top assertion macros
// shorthands for clocked checks with reset disable, used by the top level
// ----------------------------------------------------------------------------
`ifndef NORMAL_CDF_APPROX_TOP_ASSERT_SVH
`define NORMAL_CDF_APPROX_TOP_ASSERT_SVH

// same-cycle check, qualified by an enable
`define NCDF_CHECK(lbl, en, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) \
        else $error(msg);

// next-cycle check, qualified by an enable
`define NCDF_CHECK_NEXT(lbl, en, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cond)) \
        else $error(msg);

`endif

### src/ncdf_pkg.sv
// ----------------------------------------------------------------------------
// ncdf_pkg
// fixed-point constants for the normal cdf pipeline (q30 unless noted)
// ----------------------------------------------------------------------------
package ncdf_pkg;

    localparam int unsigned LATENCY = 60;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [30:0] INV_SQRT2_Q31 = 31'd1518500250;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic [31:0] COEF_P =
        32'((64'd327591100 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);

    localparam logic [31:0] MAG_A1 =
        32'((64'd254829592 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] MAG_A2 =
        32'((64'd284496736 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] MAG_A3 =
        32'((64'd1421413741 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] MAG_A4 =
        32'((64'd1453152027 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] MAG_A5 =
        32'((64'd1061405429 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);

    localparam logic signed [31:0] COEF_A1 = $signed(MAG_A1);
    localparam logic signed [31:0] COEF_A2 = -$signed(MAG_A2);
    localparam logic signed [31:0] COEF_A3 = $signed(MAG_A3);
    localparam logic signed [31:0] COEF_A4 = -$signed(MAG_A4);
    localparam logic signed [31:0] COEF_A5 = $signed(MAG_A5);

    // coefficient added after each horner multiply, none after the last
    localparam logic signed [31:0] HORNER_ADD [5] =
        '{COEF_A4, COEF_A3, COEF_A2, COEF_A1, 32'sd0};

    // number of terms in the nested exp series
    localparam int unsigned EXP_TERMS = 12;

endpackage

### src/normal_cdf_approx_top.sv
// ----------------------------------------------------------------------------
// normal_cdf_approx_top
// standard normal cdf of a signed q4.12 argument, unsigned q0.16 result
//
// input channel: in_valid / in_stall with x_value; output channel:
// out_valid / out_stall with probability. a transfer happens at a clock
// edge with valid high and stall low.
// fully pipelined: one transfer per cycle in and out while the output
// is not stalled, 60 register stages; a result sits in the output
// register prob_reg until it transfers out. the depth is set by the
// 31-step reciprocal divider feeding the horner chain and by the
// 12-term exp series, four stages a term, running beside it.
// a stalled output freezes every stage, and in_stall follows it in the
// same cycle, so nothing is dropped or repeated.
// reset clears the stage valid bits only; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`include "normal_cdf_approx_top_assert.svh"

module normal_cdf_approx_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] x_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [15:0] probability
);

    localparam int LAT = ncdf_pkg::LATENCY;
    localparam int TERMS = ncdf_pkg::EXP_TERMS;

    logic adv;
    logic [LAT:1] vld_reg;
    logic [58:1] neg_reg;

    // front stages
    logic [16:0] ax1_reg, ax1_next;
    logic [32:0] u2_reg, u2_next;
    logic [35:0] w2_reg, w2_next;
    logic [33:0] sq;
    logic [61:0] pm3_reg;
    logic [31:0] d4_reg, d4_next;

    // exp range reduction and delay lines
    logic [35:0] kr_reg [6];
    logic [5:0]  kq_reg [6];
    logic [29:0] r_reg [8:52];
    logic [5:0]  k_reg [8:56];

    // reciprocal divider
    logic [31:0] dv_rem_reg [31];
    logic [30:0] dv_q_reg [31];
    logic [31:0] dv_d_reg [31];

    // horner chain
    logic [61:0] hp_reg [5];
    logic        hs_reg [5];
    logic [30:0] hta_reg [5];
    logic signed [31:0] hh_reg [5];
    logic [30:0] htb_reg [5];
    logic [30:0] hd_reg [46:57];

    // exp series
    logic [60:0] ep_reg [TERMS];
    logic [30:0] ea_reg [TERMS];
    logic [62:0] em_reg [TERMS];
    logic [30:0] eb_reg [TERMS];
    logic [30:0] eg_reg [TERMS];

    // back end
    logic [32:0] ex_sh;
    logic [30:0] ex_reg, ex_next;
    logic [61:0] pr_reg;
    logic [31:0] c_round;
    logic [30:0] c_clamp;
    logic [31:0] v_reg, v_next;
    logic [32:0] p_round;
    logic [15:0] prob_reg, prob_next;

    assign adv = !(vld_reg[LAT] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[LAT];
    assign probability = prob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-1:1], in_valid};
        end
    end

    always_comb
    begin
        ax1_next = x_value[15] ? 17'(17'h10000 - {1'b0, x_value}) : {1'b0, x_value};
        u2_next = 33'((48'(ax1_reg) * 48'(ncdf_pkg::INV_SQRT2_Q31) + 48'd4096) >> 13);
        // square taken at the input so the exp branch lines up with the horner branch
        sq = 34'(ax1_next) * 34'(ax1_next);
        w2_next = {sq[30:0], 5'b0};
        d4_next = 32'(ncdf_pkg::ONE_Q30) + 32'((pm3_reg + (62'd1 << 29)) >> 30);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg <= {neg_reg[57:1], x_value[15]};
            ax1_reg <= ax1_next;
            u2_reg <= u2_next;
            w2_reg <= w2_next;
            pm3_reg <= 62'(u2_reg) * 62'(ncdf_pkg::COEF_P);
            d4_reg <= d4_next;
            r_reg[8] <= kr_reg[5][29:0];
            for (int s = 9; s <= 52; s++)
            begin
                r_reg[s] <= r_reg[s-1];
            end
            k_reg[8] <= kq_reg[5];
            for (int s = 9; s <= 56; s++)
            begin
                k_reg[s] <= k_reg[s-1];
            end
            hd_reg[46] <= hh_reg[4][31] ? 31'd0 : hh_reg[4][30:0];
            for (int s = 47; s <= 57; s++)
            begin
                hd_reg[s] <= hd_reg[s-1];
            end
        end
    end

    // k = floor(w / ln2), one quotient bit per stage
    for (genvar b = 0; b < 6; b++)
    begin : g_kdiv
        localparam int SH = 5 - b;
        logic [35:0] rin;
        logic [5:0]  qin;
        logic [35:0] lim;
        if (b == 0)
        begin : g_first
            assign rin = w2_reg;
            assign qin = '0;
        end
        else
        begin : g_rest
            assign rin = kr_reg[b-1];
            assign qin = kq_reg[b-1];
        end
        assign lim = 36'(ncdf_pkg::LN2_Q30) << SH;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rin >= lim)
                begin
                    kr_reg[b] <= rin - lim;
                    kq_reg[b] <= qin | 6'(1 << SH);
                end
                else
                begin
                    kr_reg[b] <= rin;
                    kq_reg[b] <= qin;
                end
            end
        end
    end

    // t = round(2^60 / d): restoring division, one quotient bit per stage
    for (genvar i = 0; i < 31; i++)
    begin : g_tdiv
        logic [31:0] rin;
        logic [31:0] din;
        logic [30:0] qin;
        logic [32:0] trial;
        logic        ge;
        if (i == 0)
        begin : g_first
            // upper dividend bits of 2^60 + d/2 reduce to 2^29
            assign rin = 32'h2000_0000;
            assign din = d4_reg;
            assign qin = '0;
        end
        else
        begin : g_rest
            assign rin = dv_rem_reg[i-1];
            assign din = dv_d_reg[i-1];
            assign qin = dv_q_reg[i-1];
        end
        assign trial = {rin, din[31-i]};
        assign ge = trial >= {1'b0, din};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[i] <= ge ? 32'(trial - {1'b0, din}) : trial[31:0];
                dv_q_reg[i] <= {qin[29:0], ge};
                dv_d_reg[i] <= din;
            end
        end
    end

    // horner in t, products rounded on magnitude
    for (genvar j = 0; j < 5; j++)
    begin : g_horner
        logic signed [31:0] hin;
        logic [30:0] tin;
        logic [31:0] hneg;
        logic [30:0] habs;
        logic [31:0] rnd;
        logic signed [31:0] sv;
        if (j == 0)
        begin : g_first
            assign hin = ncdf_pkg::COEF_A5;
            assign tin = dv_q_reg[30];
        end
        else
        begin : g_rest
            assign hin = hh_reg[j-1];
            assign tin = htb_reg[j-1];
        end
        assign hneg = 32'(-hin);
        assign habs = hin[31] ? hneg[30:0] : hin[30:0];
        assign rnd = 32'((hp_reg[j] + (62'd1 << 29)) >> 30);
        assign sv = hs_reg[j] ? -$signed(rnd) : $signed(rnd);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hp_reg[j] <= 62'(habs) * 62'(tin);
                hs_reg[j] <= hin[31];
                hta_reg[j] <= tin;
                hh_reg[j] <= sv + ncdf_pkg::HORNER_ADD[j];
                htb_reg[j] <= hta_reg[j];
            end
        end
    end

    // nested series for exp(-r), terms 12 down to 1, four stages a term
    for (genvar m = 0; m < TERMS; m++)
    begin : g_series
        localparam int unsigned N = TERMS - m;
        localparam logic [31:0] RECIP = 32'(64'd4294967295 / N);
        logic [30:0] gin;
        logic [30:0] qe;
        logic [30:0] qn;
        logic [30:0] rm;
        logic [30:0] quo;
        if (m == 0)
        begin : g_first
            assign gin = ncdf_pkg::ONE_Q30;
        end
        else
        begin : g_rest
            assign gin = eg_reg[m-1];
        end
        assign qe = 31'(em_reg[m] >> 32);
        assign qn = 31'(36'(qe) * 36'(N));
        assign rm = eb_reg[m] - qn;
        // reciprocal estimate is exact or one short
        assign quo = (rm >= 31'(N)) ? qe + 31'd1 : qe;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ep_reg[m] <= 61'(gin) * 61'(r_reg[8 + 4*m]);
                ea_reg[m] <= 31'((ep_reg[m] + (61'd1 << 29)) >> 30) + 31'(N / 2);
                em_reg[m] <= 63'(ea_reg[m]) * 63'(RECIP);
                eb_reg[m] <= ea_reg[m];
                eg_reg[m] <= ncdf_pkg::ONE_Q30 - quo;
            end
        end
    end

    always_comb
    begin
        // round(g / 2^k) as ((2g >> k) + 1) >> 1, exact for k = 0 too
        ex_sh = {1'b0, eg_reg[TERMS-1], 1'b0} >> k_reg[56];
        ex_next = 31'((ex_sh + 33'd1) >> 1);
        c_round = 32'((pr_reg + (62'd1 << 29)) >> 30);
        c_clamp = (c_round > 32'(ncdf_pkg::ONE_Q30)) ? ncdf_pkg::ONE_Q30 : c_round[30:0];
        v_next = neg_reg[58] ? {1'b0, c_clamp} : 32'h8000_0000 - {1'b0, c_clamp};
        p_round = (33'(v_reg) + 33'd16384) >> 15;
        prob_next = (p_round > 33'd65535) ? 16'hFFFF : p_round[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg <= ex_next;
            pr_reg <= 62'(hd_reg[57]) * 62'(ex_reg);
            v_reg <= v_next;
            prob_reg <= prob_next;
        end
    end

    `NCDF_CHECK(a_t_range, vld_reg[35], dv_q_reg[30] <= ncdf_pkg::ONE_Q30, "t above one")
    `NCDF_CHECK(a_k_range, vld_reg[7], kq_reg[5] < 6'd62, "exp shift out of range")
    `NCDF_CHECK(a_r_range, vld_reg[7], kr_reg[5] < 36'(ncdf_pkg::LN2_Q30), "bad exp remainder")
    `NCDF_CHECK(a_exp_range, vld_reg[56], eg_reg[TERMS-1] <= ncdf_pkg::ONE_Q30, "exp above one")
    `NCDF_CHECK_NEXT(a_stall_freeze, !adv, $stable(vld_reg), "pipeline moved while stalled")

endmodule
